@@ design/bmhq_pkg.sv @@
package bmhq_pkg;

	localparam int KEY_W     = 32;
	localparam int CNT_W     = 7;
	localparam int DEPTH_DEF = 64;
	localparam int TDATA_S_W = 32;
	localparam int TDATA_M_W = 40;

	localparam logic [CNT_W-1:0] LIMIT_RST = CNT_W'(64);

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_DELETE = 1'b1
	} opcode_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INS_UP,
		S_INS_CMP,
		S_DEL_LAST,
		S_DEL_KEY,
		S_DEL_DOWN,
		S_DEL_L,
		S_DEL_R,
		S_FINISH
	} state_t;

	typedef enum logic [3:0] {
		MEM_NONE,
		MEM_RD_PARENT,
		MEM_RD_ROOT,
		MEM_RD_LAST,
		MEM_RD_LEFT,
		MEM_RD_RIGHT,
		MEM_WR_KEY,
		MEM_WR_PARENT,
		MEM_WR_CHILD
	} mem_op_t;

	typedef enum logic [2:0] {
		POS_HOLD,
		POS_NEW,
		POS_ROOT,
		POS_UP,
		POS_CHILD
	} pos_op_t;

	typedef struct packed {
		logic    load_item;
		status_t item_status;
		logic    cnt_inc;
		logic    cnt_dec;
		pos_op_t pos_op;
		mem_op_t mem_op;
		logic    rem_load;
		logic    key_from_rd;
		logic    chl_load;
		logic    pick_pair;
		logic    emit;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic at_root;
		logic key_lt_parent;
		logic leaf;
		logic kid_is_last;
		logic key_gt_child;
		logic out_free;
	} sts_t;

endpackage

@@ design/bmhq_ctrl.sv @@
module bmhq_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic                 opcode,
	input  bmhq_pkg::sts_t       sts,
	output bmhq_pkg::cmd_t       cmd
);
	import bmhq_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d         = state_q;
		s_tready        = 1'b0;
		cmd             = '0;
		cmd.item_status = ST_OK;
		cmd.pos_op      = POS_HOLD;
		cmd.mem_op      = MEM_NONE;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_item = 1'b1;
					if (opcode_t'(opcode) == OP_INSERT) begin
						if (sts.full) begin
							cmd.item_status = ST_FULL;
							state_d         = S_FINISH;
						end else begin
							cmd.cnt_inc = 1'b1;
							cmd.pos_op  = POS_NEW;
							state_d     = S_INS_UP;
						end
					end else begin
						if (sts.empty) begin
							cmd.item_status = ST_EMPTY;
							state_d         = S_FINISH;
						end else begin
							cmd.mem_op = MEM_RD_ROOT;
							state_d    = S_DEL_LAST;
						end
					end
				end
			end
			S_INS_UP: begin
				if (sts.at_root) begin
					cmd.mem_op = MEM_WR_KEY;
					state_d    = S_FINISH;
				end else begin
					cmd.mem_op = MEM_RD_PARENT;
					state_d    = S_INS_CMP;
				end
			end
			S_INS_CMP: begin
				if (sts.key_lt_parent) begin
					cmd.mem_op = MEM_WR_PARENT;
					cmd.pos_op = POS_UP;
					state_d    = S_INS_UP;
				end else begin
					cmd.mem_op = MEM_WR_KEY;
					state_d    = S_FINISH;
				end
			end
			S_DEL_LAST: begin
				cmd.rem_load = 1'b1;
				cmd.mem_op   = MEM_RD_LAST;
				state_d      = S_DEL_KEY;
			end
			S_DEL_KEY: begin
				cmd.key_from_rd = 1'b1;
				cmd.cnt_dec     = 1'b1;
				cmd.pos_op      = POS_ROOT;
				state_d         = S_DEL_DOWN;
			end
			S_DEL_DOWN: begin
				if (sts.leaf) begin
					cmd.mem_op = MEM_WR_KEY;
					state_d    = S_FINISH;
				end else begin
					cmd.mem_op = MEM_RD_LEFT;
					state_d    = S_DEL_L;
				end
			end
			S_DEL_L: begin
				cmd.chl_load = 1'b1;
				if (!sts.kid_is_last) begin
					cmd.mem_op = MEM_RD_RIGHT;
					state_d    = S_DEL_R;
				end else if (sts.key_gt_child) begin
					cmd.mem_op = MEM_WR_CHILD;
					cmd.pos_op = POS_CHILD;
					state_d    = S_DEL_DOWN;
				end else begin
					cmd.mem_op = MEM_WR_KEY;
					state_d    = S_FINISH;
				end
			end
			S_DEL_R: begin
				cmd.pick_pair = 1'b1;
				if (sts.key_gt_child) begin
					cmd.mem_op = MEM_WR_CHILD;
					cmd.pos_op = POS_CHILD;
					state_d    = S_DEL_DOWN;
				end else begin
					cmd.mem_op = MEM_WR_KEY;
					state_d    = S_FINISH;
				end
			end
			S_FINISH: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

@@ design/bmhq_datapath.sv @@
module bmhq_datapath #(
	parameter int DEPTH = bmhq_pkg::DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [bmhq_pkg::KEY_W-1:0]      key_in,
	input  logic [bmhq_pkg::CNT_W-1:0]      limit,
	input  bmhq_pkg::cmd_t                  cmd,
	output bmhq_pkg::sts_t                  sts,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [bmhq_pkg::TDATA_M_W-1:0]  m_tdata,
	output logic [1:0]                      m_tuser
);
	import bmhq_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SW = (AW > CNT_W) ? AW : CNT_W;
	localparam logic [CNT_W-1:0] DEPTH_CAP =
		CNT_W'((DEPTH > (2 ** CNT_W - 1)) ? (2 ** CNT_W - 1) : DEPTH);

	logic [KEY_W-1:0] mem [DEPTH];
	logic [KEY_W-1:0] rdata_q;

	logic [KEY_W-1:0] key_q;
	logic [KEY_W-1:0] rem_q;
	logic [KEY_W-1:0] chl_q;
	status_t          stat_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] pos_q;
	logic [CNT_W-1:0] kid_q;

	logic             out_valid_q;
	status_t          out_stat_q;
	logic [KEY_W-1:0] out_key_q;
	logic [CNT_W-1:0] out_cnt_q;

	logic [CNT_W-1:0] limit_eff;
	logic [CNT_W:0]   kid_wide;
	logic             right_lt;
	logic [KEY_W-1:0] child_key;
	logic [CNT_W-1:0] child_slot;
	logic [CNT_W-1:0] slot;
	logic [SW-1:0]    slot_w;
	logic [AW-1:0]    addr;
	logic             mem_we;
	logic             mem_re;
	logic [KEY_W-1:0] wdata;

	assign limit_eff  = (limit < DEPTH_CAP) ? limit : DEPTH_CAP;
	assign kid_wide   = {pos_q, 1'b0};
	assign right_lt   = $signed(rdata_q) < $signed(chl_q);
	assign child_key  = (cmd.pick_pair && right_lt) ? rdata_q : (cmd.pick_pair ? chl_q : rdata_q);
	assign child_slot = (cmd.pick_pair && right_lt) ? kid_q + CNT_W'(1) : kid_q;

	always_comb begin
		sts.full          = cnt_q >= limit_eff;
		sts.empty         = cnt_q == '0;
		sts.at_root       = pos_q == CNT_W'(1);
		sts.key_lt_parent = $signed(key_q) < $signed(rdata_q);
		sts.leaf          = kid_wide > {1'b0, cnt_q};
		sts.kid_is_last   = kid_q == cnt_q;
		sts.key_gt_child  = $signed(key_q) > $signed(child_key);
		sts.out_free      = !out_valid_q || m_tready;
	end

	always_comb begin
		slot   = pos_q;
		mem_we = 1'b0;
		mem_re = 1'b0;
		wdata  = key_q;
		case (cmd.mem_op)
			MEM_RD_PARENT: begin
				slot   = pos_q >> 1;
				mem_re = 1'b1;
			end
			MEM_RD_ROOT: begin
				slot   = CNT_W'(1);
				mem_re = 1'b1;
			end
			MEM_RD_LAST: begin
				slot   = cnt_q;
				mem_re = 1'b1;
			end
			MEM_RD_LEFT: begin
				slot   = kid_wide[CNT_W-1:0];
				mem_re = 1'b1;
			end
			MEM_RD_RIGHT: begin
				slot   = kid_q + CNT_W'(1);
				mem_re = 1'b1;
			end
			MEM_WR_KEY: begin
				mem_we = 1'b1;
			end
			MEM_WR_PARENT: begin
				mem_we = 1'b1;
				wdata  = rdata_q;
			end
			MEM_WR_CHILD: begin
				mem_we = 1'b1;
				wdata  = child_key;
			end
			default: begin
				slot = pos_q;
			end
		endcase
	end

	assign slot_w = SW'(slot) - SW'(1);
	assign addr   = slot_w[AW-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[addr] <= wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			key_q <= key_in;
		end else if (cmd.key_from_rd) begin
			key_q <= rdata_q;
		end
		if (cmd.load_item) begin
			rem_q <= '0;
		end else if (cmd.rem_load) begin
			rem_q <= rdata_q;
		end
		if (cmd.chl_load) begin
			chl_q <= rdata_q;
		end
		if (cmd.mem_op == MEM_RD_LEFT) begin
			kid_q <= kid_wide[CNT_W-1:0];
		end
		case (cmd.pos_op)
			POS_NEW:   pos_q <= cnt_q + CNT_W'(1);
			POS_ROOT:  pos_q <= CNT_W'(1);
			POS_UP:    pos_q <= pos_q >> 1;
			POS_CHILD: pos_q <= child_slot;
			default:   pos_q <= pos_q;
		endcase
		if (cmd.load_item) begin
			stat_q <= cmd.item_status;
		end
		if (cmd.emit) begin
			out_stat_q <= stat_q;
			out_key_q  <= rem_q;
			out_cnt_q  <= cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (cmd.cnt_dec) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_stat_q;
	assign m_tdata  = {{(TDATA_M_W - KEY_W - CNT_W){1'b0}}, out_cnt_q, out_key_q};

endmodule

@@ design/binary_min_heap_queue_core.sv @@
// Binary min-heap priority queue of signed 32-bit keys.
// Input channel s_*: one beat per operation. s_tuser is the opcode (0 insert
// s_tdata as a key, 1 remove the minimum); s_tdata is ignored on a removal.
// Output channel m_*: one beat per operation. m_tuser is the status (0 ok,
// 1 full on insert, 2 empty on removal); m_tdata carries the removed key
// (zero unless a removal succeeded) and the key count after the operation.
// Config channel cfg_*: writes the capacity limit; the smaller of it and
// DEPTH applies. Write it only while no operation is in flight.
// One operation is processed at a time; a new input beat is taken only after
// the previous result is registered. A full/empty error goes straight to the
// result; an insert compares the key with one parent after another up the
// tree, and a removal walks down through the nodes with children. The key
// store has a single port: one read or one write per cycle, with read data
// registered, and each operation walks one tree level after another.
// Reset clears the key count to zero and the limit to 64; the store itself is
// not cleared. A stalled output holds its beat; the next input is taken as
// soon as the core is idle, and its result waits until the held beat leaves.
module binary_min_heap_queue_core #(
	parameter int DEPTH = bmhq_pkg::DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [bmhq_pkg::TDATA_S_W-1:0]  s_tdata,   // [31:0] key_in
	input  logic [0:0]                      s_tuser,   // [0] opcode
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [bmhq_pkg::TDATA_M_W-1:0]  m_tdata,   // [31:0] removed_key, [38:32] count_out
	output logic [1:0]                      m_tuser,   // [1:0] status
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bmhq_pkg::CNT_W-1:0]      cfg_data   // [6:0] capacity_limit
);
	import bmhq_pkg::*;

	cmd_t             cmd;
	sts_t             sts;
	logic [CNT_W-1:0] limit_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RST;
		end else if (cfg_valid) begin
			limit_q <= cfg_data;
		end
	end

	bmhq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.opcode   (s_tuser[0]),
		.sts      (sts),
		.cmd      (cmd)
	);

	bmhq_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.key_in   (s_tdata[KEY_W-1:0]),
		.limit    (limit_q),
		.cmd      (cmd),
		.sts      (sts),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

@@ sim/tb_top.sv @@
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bmhq_pkg::*;

	localparam int HEAP_DEPTH = DEPTH_DEF;
	localparam int IDLE_LIMIT = 4000;

	typedef struct packed {
		opcode_t           op;
		logic signed [31:0] key;
	} heap_req_t;

	typedef struct packed {
		status_t            status;
		logic signed [31:0] removed;
		logic [CNT_W-1:0]   held;
	} heap_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [TDATA_S_W-1:0] s_tdata;
	logic [0:0]           s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [TDATA_M_W-1:0] m_tdata;
	logic [1:0]           m_tuser;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CNT_W-1:0]     cfg_data;

	binary_min_heap_queue_core #(.DEPTH(HEAP_DEPTH)) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	// predictor state
	logic signed [31:0] heap_keys [1:HEAP_DEPTH];
	int                 keys_held;
	logic [CNT_W-1:0]   limit_reg;

	heap_req_t    pending_ops [$];
	heap_result_t heap_expected [$];

	int in_driven, in_beats, cfg_beats, out_beats;
	int mismatches, idle_cycles;
	int n_insert, n_delete, n_full, n_empty, peak_held, n_limits;
	int s_idle_pct, m_stall_pct;
	bit calm;
	int s_gap_left, m_stall_left;
	heap_req_t drive_req;

	function automatic heap_result_t apply_heap_op(heap_req_t req);
		heap_result_t       res;
		int                 lim;
		int                 pos;
		int                 kid;
		bit                 done;
		logic signed [31:0] last;
		res.status  = ST_OK;
		res.removed = '0;
		if (req.op == OP_INSERT) begin
			lim = (int'(limit_reg) < HEAP_DEPTH) ? int'(limit_reg) : HEAP_DEPTH;
			if (keys_held >= lim) begin
				res.status = ST_FULL;
			end else begin
				keys_held++;
				pos = keys_held;
				while (pos > 1 && req.key < heap_keys[pos / 2]) begin
					heap_keys[pos] = heap_keys[pos / 2];
					pos = pos / 2;
				end
				heap_keys[pos] = req.key;
			end
		end else if (keys_held == 0) begin
			res.status = ST_EMPTY;
		end else begin
			res.removed = heap_keys[1];
			last = heap_keys[keys_held];
			keys_held--;
			pos = 1;
			done = 0;
			while (!done && 2 * pos <= keys_held) begin
				kid = 2 * pos;
				if (kid != keys_held && heap_keys[kid + 1] < heap_keys[kid])
					kid++;
				if (last > heap_keys[kid]) begin
					heap_keys[pos] = heap_keys[kid];
					pos = kid;
				end else begin
					done = 1;
				end
			end
			heap_keys[pos] = last;
		end
		res.held = CNT_W'(keys_held);
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		mismatches++;
		if (mismatches <= 30)
			$display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
	endtask

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// monitor, predictor and watchdog
	always @(posedge clk) begin
		heap_result_t got;
		heap_result_t want;
		heap_req_t    req;
		if (arst_n) begin
			idle_cycles++;
			if (m_tvalid && m_tready) begin
				idle_cycles = 0;
				out_beats++;
				got.status  = status_t'(m_tuser);
				got.removed = m_tdata[31:0];
				got.held    = m_tdata[38:32];
				if (heap_expected.size() == 0) begin
					report_mismatch("unexpected result beat", {m_tuser, m_tdata}, 0);
				end else begin
					want = heap_expected.pop_front();
					if (got.status != want.status)
						report_mismatch("status", got.status, want.status);
					if (got.removed != want.removed)
						report_mismatch("removed_key", got.removed, want.removed);
					if (got.held != want.held)
						report_mismatch("count_out", got.held, want.held);
				end
			end
			if (s_tvalid && s_tready) begin
				idle_cycles = 0;
				in_beats++;
				req.op  = opcode_t'(s_tuser[0]);
				req.key = s_tdata;
				want = apply_heap_op(req);
				heap_expected.push_back(want);
				if (req.op == OP_INSERT) n_insert++;
				else n_delete++;
				if (want.status == ST_FULL) n_full++;
				if (want.status == ST_EMPTY) n_empty++;
				if (keys_held > peak_held) peak_held = keys_held;
			end
			if (cfg_valid && cfg_ready) begin
				idle_cycles = 0;
				cfg_beats++;
				limit_reg = cfg_data;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no beat for %0d cycles", $realtime, IDLE_LIMIT);
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// input driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (s_tvalid && in_beats < in_driven) begin
				// hold until taken
			end else if (s_gap_left > 0) begin
				s_tvalid <= 1'b0;
				s_gap_left--;
			end else if (pending_ops.size() == 0) begin
				s_tvalid <= 1'b0;
			end else if (!calm && $urandom_range(0, 99) < s_idle_pct) begin
				s_tvalid <= 1'b0;
				s_gap_left = $urandom_range(0, 6);
			end else begin
				drive_req = pending_ops.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= drive_req.key;
				s_tuser  <= drive_req.op;
				in_driven++;
			end
		end
	end

	// result sink
	always @(negedge clk) begin
		if (arst_n) begin
			if (m_stall_left > 0) begin
				m_tready <= 1'b0;
				m_stall_left--;
			end else if (!calm && $urandom_range(0, 99) < m_stall_pct) begin
				m_tready <= 1'b0;
				m_stall_left = $urandom_range(0, 6);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	function automatic logic signed [31:0] pick_key();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom;
			4, 5:       return $signed(32'($urandom_range(0, 8))) - 4;
			6:          return 32'sh7FFF_FFFF - $urandom_range(0, 3);
			7:          return 32'sh8000_0000 + $urandom_range(0, 3);
			default:    return $signed(32'($urandom_range(0, 200))) - 100;
		endcase
	endfunction

	task automatic push_op(opcode_t op, logic signed [31:0] key);
		heap_req_t req;
		req.op  = op;
		req.key = key;
		pending_ops.push_back(req);
	endtask

	task automatic push_random(int n, int ins_pct);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < ins_pct)
				push_op(OP_INSERT, pick_key());
			else
				push_op(OP_DELETE, $urandom);
		end
	endtask

	task automatic drain();
		while (pending_ops.size() != 0 || in_beats != in_driven || heap_expected.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_limit(logic [CNT_W-1:0] value);
		int seen;
		drain();
		seen = cfg_beats;
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(negedge clk); while (cfg_beats == seen);
		cfg_valid <= 1'b0;
		n_limits++;
	endtask

	task automatic set_pace(int s_pct, int m_pct);
		s_idle_pct  = s_pct;
		m_stall_pct = m_pct;
	endtask

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		m_tready  = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		keys_held = 0;
		limit_reg = LIMIT_RST;
		calm      = 0;
		set_pace(30, 30);
		for (int i = 1; i <= HEAP_DEPTH; i++) heap_keys[i] = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset limit, extremes, ties, empty and full
		push_op(OP_DELETE, 32'shFFFF_FFFF);
		push_op(OP_INSERT, 32'sh7FFF_FFFF);
		push_op(OP_INSERT, 32'sh8000_0000);
		push_op(OP_INSERT, -1);
		push_op(OP_INSERT, -2);
		push_op(OP_INSERT, 0);
		push_op(OP_INSERT, 1);
		push_op(OP_INSERT, 5);
		push_op(OP_INSERT, 5);
		push_op(OP_INSERT, 5);
		push_op(OP_INSERT, 3);
		for (int i = 0; i < 11; i++) push_op(OP_DELETE, 0);
		write_limit(7'd1);
		push_op(OP_INSERT, 9);
		push_op(OP_INSERT, 9);
		push_op(OP_DELETE, 0);
		push_op(OP_DELETE, 0);
		write_limit(7'd0);
		push_op(OP_INSERT, 4);
		push_op(OP_DELETE, 0);

		// random: fill past the store depth, then squeeze the limit below the count
		write_limit(7'd127);
		set_pace(0, 0);
		push_random(80, 95);
		write_limit(7'd5);
		set_pace(40, 20);
		push_random(60, 40);
		write_limit(7'd64);
		set_pace(20, 50);
		push_random(100, 55);
		write_limit(CNT_W'($urandom_range(1, 64)));
		set_pace(0, 40);
		push_random(100, 50);
		write_limit(CNT_W'($urandom_range(65, 126)));
		set_pace(50, 0);
		push_random(100, 60);
		write_limit(7'd2);
		set_pace(25, 25);
		push_random(60, 50);
		write_limit(7'd64);
		set_pace(30, 30);
		push_random(90, 35);
		write_limit(CNT_W'($urandom_range(1, 64)));
		calm = 1;
		push_random(120, 55);

		drain();
		repeat (30) @(posedge clk);
		if (heap_expected.size() != 0)
			report_mismatch("results never delivered", heap_expected.size(), 0);
		$display("covered %0d inserts and %0d deletes, %0d refused as full, %0d as empty",
			n_insert, n_delete, n_full, n_empty);
		$display("deepest heap %0d keys over %0d limit writes; %0d result beats checked",
			peak_held, n_limits, out_beats);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

@@ sim.f @@
design/bmhq_pkg.sv
design/bmhq_ctrl.sv
design/bmhq_datapath.sv
design/binary_min_heap_queue_core.sv
sim/tb_top.sv
